// ===== src/max_extract_store_core_macros.svh =====
// Assertion macros for the max_extract_store core.
// Include once per file that asserts; no other dependencies.
`ifndef MAX_EXTRACT_STORE_CORE_MACROS_SVH
`define MAX_EXTRACT_STORE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, idle in reset
`define MES_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication, sampled on clk, idle in reset
`define MES_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define MES_ASSERT_IMP(lbl, a, b)
`define MES_ASSERT_NEXT(lbl, a, b)
`endif

`endif

// ===== src/mes_pkg.sv =====
// Shared types, constants and helpers for the max_extract_store core.
// No dependencies; imported by every module of the core.
package mes_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COUNT_W-1:0] held_t;

    // control broadcast to every cell
    typedef struct packed {
        logic   put;
        logic   take;
        value_t new_value;
    } cell_ctrl_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   gt;
        value_t value;
    } cell_link_t;

    // one result word
    typedef struct packed {
        value_t taken;
        logic   done;
        held_t  held;
    } out_word_t;

    function automatic held_t to_held(input cnt_t cnt);
        return COUNT_W'(cnt);
    endfunction

endpackage

// ===== src/max_extract_store_core.sv =====
// Top level of the max_extract_store core: sorted cell row, count, output buffer.
// Depends on mes_pkg, mes_cell, mes_obuf and max_extract_store_core_macros.svh.
//
// Bounded max-priority store. A put (op = 0) inserts item_value, or is refused with
// done_res = 0 when CAPACITY items are held. A take (op = 1) removes and returns the
// largest held value, or returns done_res = 0 and taken_value = 0 when empty. Every
// request yields exactly one result word carrying held_count, the item count after
// the request (low 7 bits). The store is a row of CAPACITY identical cells kept in
// descending order: cell 0 always holds the maximum. On a put each cell compares the
// new value with its own and, using its left neighbor's compare, either keeps its
// value, takes the new one, or takes its left neighbor's; on a take every cell loads
// its right neighbor. Each request finishes in its accepting cycle, the cell compare
// plus one neighbor select, and a request is taken each unstalled cycle. The result
// goes into a two-word output buffer, so one result may wait at the output while
// the next request is accepted; in_stall rises only when both buffer words are full.
// Reset empties the store at once (per-cell valid bits), with no clearing pass.
`include "max_extract_store_core_macros.svh"

module max_extract_store_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  mes_pkg::value_t       item_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mes_pkg::value_t       taken_value,
    output logic                  done_res,
    output mes_pkg::held_t        held_count
);
    import mes_pkg::*;

    cnt_t       cnt_reg;
    cnt_t       cnt_next;
    logic       in_acc;
    logic       full;
    logic       empty;
    logic       do_put;
    logic       do_take;
    cell_ctrl_t ctrl;
    cell_link_t link [CAPACITY];
    cell_link_t edge_left;
    cell_link_t edge_right;
    out_word_t  res_word;
    out_word_t  out_word;

    assign in_acc = in_valid && !in_stall;
    assign full   = (cnt_reg == CNT_W'(CAPACITY));
    assign empty  = (cnt_reg == '0);

    // issue only requests that change the store
    assign do_put  = in_acc && (op == OP_PUT) && !full;
    assign do_take = in_acc && (op == OP_TAKE) && !empty;

    assign ctrl.put       = do_put;
    assign ctrl.take      = do_take;
    assign ctrl.new_value = item_value;

    // row ends: left of cell 0 is a full slot that never yields,
    // right of the last cell is an empty slot
    assign edge_left.valid  = 1'b1;
    assign edge_left.gt     = 1'b0;
    assign edge_left.value  = '0;
    assign edge_right.valid = 1'b0;
    assign edge_right.gt    = 1'b0;
    assign edge_right.value = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_link_t left_l;
        cell_link_t right_l;
        if (i == 0)
        begin : g_first
            assign left_l = edge_left;
        end
        else
        begin : g_mid_l
            assign left_l = link[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_l = edge_right;
        end
        else
        begin : g_mid_r
            assign right_l = link[i+1];
        end
        mes_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_l),
            .right (right_l),
            .link  (link[i])
        );
    end

    // advance count on a put, drop it on a take
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_put)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // result word: cell 0 holds the maximum before the shift
    assign res_word.taken = do_take ? link[0].value : '0;
    assign res_word.done  = do_put || do_take;
    assign res_word.held  = to_held(cnt_next);

    mes_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_word   (res_word),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_word  (out_word),
        .out_stall (out_stall)
    );

    assign taken_value = out_word.taken;
    assign done_res    = out_word.done;
    assign held_count  = out_word.held;

    `MES_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `MES_ASSERT_IMP(a_head_valid, 1'b1, link[0].valid == !empty)
    `MES_ASSERT_IMP(a_sorted_head, link[0].valid && link[1].valid, link[0].value >= link[1].value)
    `MES_ASSERT_NEXT(a_full_put, in_acc && (op == OP_PUT) && full, cnt_reg == CNT_W'(CAPACITY))

endmodule

// ===== src/mes_cell.sv =====
// One cell of the sorted store: holds one value, shifts with its neighbors.
// Depends on mes_pkg.
module mes_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mes_pkg::cell_ctrl_t ctrl,
    input  mes_pkg::cell_link_t left,
    input  mes_pkg::cell_link_t right,
    output mes_pkg::cell_link_t link
);
    import mes_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;
    logic   gt;

    // new value belongs at or above this cell
    assign gt = !valid_reg || (ctrl.new_value > value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.put)
        begin
            if (left.gt)
            begin
                value_next = left.value;
            end
            else if (gt)
            begin
                value_next = ctrl.new_value;
            end
            valid_next = valid_reg | left.valid;
        end
        else if (ctrl.take)
        begin
            value_next = right.value;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

// ===== src/mes_obuf.sv =====
// Two-word output buffer: main register plus skid register.
// Depends on mes_pkg.
module mes_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  mes_pkg::out_word_t in_word,
    output logic               in_stall,
    output logic               out_valid,
    output mes_pkg::out_word_t out_word,
    input  logic               out_stall
);
    import mes_pkg::*;

    out_word_t main_reg;
    out_word_t main_next;
    out_word_t skid_reg;
    out_word_t skid_next;
    logic      main_valid_reg;
    logic      main_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    logic      in_acc;
    logic      out_acc;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_acc  = main_valid_reg && !out_stall;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_acc)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (!main_valid_reg || out_acc)
            begin
                main_next       = in_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_acc)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

endmodule

// ===== verif/max_extract_store_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for max_extract_store_core: watches both word channels, predicts each result.
// Depends on mes_pkg for the value, count and result word types.
module max_extract_store_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  logic            op,
    input  mes_pkg::value_t item_value,
    input  logic            out_valid,
    input  logic            out_stall,
    input  mes_pkg::value_t taken_value,
    input  logic            done_res,
    input  mes_pkg::held_t  held_count,
    output int              err_count,
    output int              pending
);
    import mes_pkg::*;

    // shadow copy of the store: unordered slots plus the number held
    value_t      slots [CAPACITY];
    int unsigned fill;
    out_word_t   result_q [$];
    out_word_t   want;
    int          bad;

    // apply one request to the shadow store and return the word it should produce
    function automatic out_word_t serve_request(input logic kind, input value_t v);
        out_word_t   w;
        int unsigned best;
        w.taken = '0;
        w.done  = 1'b0;
        if (kind == OP_PUT)
        begin
            if (fill < CAPACITY)
            begin
                slots[fill] = v;
                fill++;
                w.done = 1'b1;
            end
        end
        else if (fill > 0)
        begin
            best = 0;
            for (int unsigned i = 1; i < fill; i++)
                if (slots[i] > slots[best])
                    best = i;
            w.taken = slots[best];
            fill--;
            slots[best] = slots[fill];
            w.done = 1'b1;
        end
        w.held = held_t'(fill);
        return w;
    endfunction

    function automatic int field_diff(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_q.delete();
            fill = 0;
            err_count <= 0;
            pending   <= 0;
        end
        else
        begin
            bad = 0;
            // results leave before requests enter: a word cannot answer a same-edge request
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
                             $time, taken_value, done_res, held_count);
                    bad = 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    bad = field_diff("taken_value", 16'(want.taken), 16'(taken_value))
                        + field_diff("done_res", 16'(want.done), 16'(done_res))
                        + field_diff("held_count", 16'(want.held), 16'(held_count));
                end
            end
            if (in_valid && !in_stall)
                result_q.push_back(serve_request(op, item_value));
            err_count <= err_count + bad;
            pending   <= result_q.size();
        end
    end

endmodule

// ===== verif/max_extract_store_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for max_extract_store_core: clock, reset, request stimulus and verdict.
// Depends on mes_pkg, the core and max_extract_store_checker.
module max_extract_store_core_tb;
    import mes_pkg::*;

    // no accepted word on either channel for this many cycles means the block hung
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles to keep watching the output after the last expected word
    localparam int TAIL_CYCLES    = 20;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    logic   op;
    value_t item_value;
    logic   out_valid;
    logic   out_stall = 1'b0;
    value_t taken_value;
    logic   done_res;
    held_t  held_count;

    int err_count;
    int pending;
    int idle_cycles;

    // idling rates of the current phase, in percent of cycles
    int send_idle_pct;
    int stall_pct;

    max_extract_store_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .taken_value (taken_value),
        .done_res    (done_res),
        .held_count  (held_count)
    );

    max_extract_store_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .taken_value (taken_value),
        .done_res    (done_res),
        .held_count  (held_count),
        .err_count   (err_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver side: stall at the rate of the current phase, never during reset.
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: count cycles with no accepted word on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one request word and hold it until the block takes it. Idle cycles go in
    // front of the word, so valid drops only between words, never under a held one.
    task automatic send_word(input logic kind, input value_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            item_value <= value_t'($urandom);
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        item_value <= v;
        @(posedge clk);
        // in_stall read right after the edge is the value the edge sampled
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted result word has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Mix of values: many extremes and a narrow band to force equal maxima.
    function automatic value_t pick_value();
        int unsigned sel;
        sel = $urandom_range(7);
        case (sel)
            0:       return '0;
            1:       return '1;
            2, 3:    return value_t'($urandom_range(7));
            default: return value_t'($urandom);
        endcase
    endfunction

    // A run of random requests where put_pct percent are puts. A heavy put bias walks
    // the store up to full and past it; a heavy take bias walks it down through empty.
    task automatic run_burst(input int words, input int put_pct);
        logic kind;
        repeat (words)
        begin
            kind = ($urandom_range(99) < put_pct) ? OP_PUT : OP_TAKE;
            send_word(kind, pick_value());
        end
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        phase_idle  = '{0, 58, 0, 14};
        phase_stall = '{0, 0, 58, 14};

        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op         <= OP_PUT;
        item_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: take from an empty store, extremes and alternating bit patterns,
        // removal in descending order, equal maxima, and empty again at the end.
        send_word(OP_TAKE, '1);
        send_word(OP_PUT, '0);
        send_word(OP_PUT, '1);
        send_word(OP_PUT, 10'h155);
        send_word(OP_PUT, 10'h2AA);
        send_word(OP_PUT, 10'h001);
        send_word(OP_TAKE, 10'h155);
        send_word(OP_TAKE, '0);
        send_word(OP_TAKE, '1);
        send_word(OP_TAKE, 10'h2AA);
        send_word(OP_TAKE, '0);
        send_word(OP_TAKE, '0);
        send_word(OP_PUT, 10'd7);
        send_word(OP_PUT, 10'd7);
        send_word(OP_PUT, 10'd3);
        send_word(OP_TAKE, '0);
        send_word(OP_TAKE, '1);
        send_word(OP_TAKE, '0);
        send_word(OP_TAKE, '0);
        wait_drained();

        // Random: one phase per idling mode, each filling past capacity, draining past
        // empty, then mixing; pause for a full drain between phases.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            run_burst(75, 94);
            run_burst(75, 6);
            run_burst(12, 50);
            wait_drained();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (err_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== max_extract_store_core.f =====
+incdir+src
src/mes_pkg.sv
src/mes_cell.sv
src/mes_obuf.sv
src/max_extract_store_core.sv
verif/max_extract_store_checker.sv
verif/max_extract_store_core_tb.sv
